### rtl/core/rac_pkg.sv
// ----------------------------------------------------------------------------
// Rational approximation package
// Shared types and constants for the continued-fraction approximation core.
// ----------------------------------------------------------------------------
package rac_pkg;

    localparam int RESULT_WIDTH = 64;
    localparam logic [63:0] LIMIT = 64'((65'd1 << (RESULT_WIDTH - 1)) - 65'd1);
    localparam logic [5:0] SHIFT_RESET = 6'd52;
    localparam int DIV_STEPS = 128;
    localparam int MUL_LAST = 4;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NAN   = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MS_TP = 2'd0,
        MS_TQ = 2'd1,
        MS_AQ = 2'd2
    } t_mul_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_MULP,
        S_MULQ,
        S_EVAL,
        S_FIT,
        S_MULC,
        S_SHIFT,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     mul_clr;
        logic     mul_go;
        logic [1:0] mul_idx;
        t_mul_sel mul_sel;
        logic     save_p;
        logic     eval;
        logic     shift;
        logic     advance;
        logic     finish;
    } t_dp_cmd;

    typedef struct packed {
        logic is_main;
        logic fit_ok;
        logic stop;
    } t_dp_stat;

endpackage

### rtl/core/rac_ctrl.sv
// ----------------------------------------------------------------------------
// Rational approximation controller
// Sequences load, bit-serial division, multiplies and the stop test per term.
// ----------------------------------------------------------------------------
module rac_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  rac_pkg::t_dp_stat i_stat,
    output rac_pkg::t_dp_cmd  o_cmd
);

    rac_pkg::t_state r_state, n_state;
    logic [6:0]      r_cnt, n_cnt;
    logic            mul_end;

    assign mul_end = (r_cnt[2:0] == 3'(rac_pkg::MUL_LAST));
    assign o_busy  = (r_state != rac_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rac_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.mul_sel = rac_pkg::MS_TP;
        unique case (r_state)
            rac_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = rac_pkg::S_DECIDE;
                end
            end
            rac_pkg::S_DECIDE: begin
                n_cnt   = '0;
                n_state = i_stat.is_main ? rac_pkg::S_DIV : rac_pkg::S_DONE;
            end
            rac_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(rac_pkg::DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = rac_pkg::S_MULP;
                end
            end
            rac_pkg::S_MULP, rac_pkg::S_MULQ, rac_pkg::S_MULC: begin
                o_cmd.mul_sel = (r_state == rac_pkg::S_MULP) ? rac_pkg::MS_TP :
                                (r_state == rac_pkg::S_MULQ) ? rac_pkg::MS_TQ :
                                rac_pkg::MS_AQ;
                o_cmd.mul_clr = (r_cnt[2:0] == 3'd0);
                o_cmd.save_p  = (r_cnt[2:0] == 3'd0) && (r_state == rac_pkg::S_MULQ);
                o_cmd.mul_go  = !mul_end;
                o_cmd.mul_idx = r_cnt[1:0];
                n_cnt = r_cnt + 7'd1;
                if (mul_end) begin
                    n_cnt   = '0;
                    n_state = (r_state == rac_pkg::S_MULP) ? rac_pkg::S_MULQ :
                              (r_state == rac_pkg::S_MULQ) ? rac_pkg::S_EVAL :
                              rac_pkg::S_SHIFT;
                end
            end
            rac_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = rac_pkg::S_FIT;
            end
            rac_pkg::S_FIT: begin
                n_state = i_stat.fit_ok ? rac_pkg::S_MULC : rac_pkg::S_DONE;
            end
            rac_pkg::S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = rac_pkg::S_CMP;
            end
            rac_pkg::S_CMP: begin
                if (i_stat.stop) begin
                    n_state = rac_pkg::S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_cnt   = '0;
                    n_state = rac_pkg::S_DIV;
                end
            end
            rac_pkg::S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = rac_pkg::S_IDLE;
            end
            default: begin
                n_state = rac_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/rac_datapath.sv
// ----------------------------------------------------------------------------
// Rational approximation datapath
// Euclid divider, shared 32x32 multiplier, convergent update and stop test.
// ----------------------------------------------------------------------------
module rac_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [5:0]        i_cfg_wdata,
    input  logic [63:0]       i_x_bits,
    input  rac_pkg::t_dp_cmd  i_cmd,
    output rac_pkg::t_dp_stat o_stat,
    output logic              o_valid,
    output logic signed [63:0] o_numerator,
    output logic [62:0]       o_denominator,
    output logic [1:0]        o_status
);

    logic [5:0]   r_cfg_shift;
    logic [5:0]   r_s;
    logic         r_sign;
    logic         r_main;
    logic         r_first;
    logic         r_fit_ok;
    logic [1:0]   r_status;
    logic [63:0]  r_a0;
    logic [127:0] r_b;
    logic [127:0] r_d;
    logic [127:0] r_rem;
    logic [63:0]  r_p, r_q, r_p1, r_q1;
    logic [63:0]  r_part;
    logic [1:0]   r_part_sh;
    logic         r_part_vld;
    logic [127:0] r_acc;
    logic [127:0] r_prod_p;
    logic [127:0] r_shl;
    logic         r_over;
    logic         r_out_vld;
    logic signed [63:0] r_num;
    logic [62:0]  r_den;
    logic [1:0]   r_out_st;

    logic [10:0]  ex;
    logic [52:0]  mant;
    logic [10:0]  up_sh, dn_sh;
    logic [63:0]  a0_init;
    logic [127:0] b_init;
    logic [127:0] rem_sh;
    logic         rem_ge;
    logic [63:0]  mx, my;
    logic [31:0]  mxi, myj;
    logic [191:0] wide_shl;
    logic [63:0]  np_sum, nq_sum, np_val, nq_val;
    logic         np_c, nq_c, ok_p, ok_q;

    assign ex     = i_x_bits[62:52];
    assign mant   = {1'b1, i_x_bits[51:0]};
    assign up_sh  = ex - 11'd1075;
    assign dn_sh  = 11'd1075 - ex;
    assign a0_init = (ex >= 11'd1075) ? ({11'd0, mant} << up_sh[3:0]) : {11'd0, mant};
    assign b_init  = (ex >= 11'd1075) ? 128'd1 : (128'd1 << dn_sh[6:0]);

    assign rem_sh = {r_rem[126:0], r_d[127]};
    assign rem_ge = (rem_sh >= r_b);

    always_comb begin
        case (i_cmd.mul_sel)
            rac_pkg::MS_TP: begin
                mx = r_d[63:0];
                my = r_p;
            end
            rac_pkg::MS_TQ: begin
                mx = r_d[63:0];
                my = r_q;
            end
            default: begin
                mx = r_a0;
                my = r_q;
            end
        endcase
        mxi = i_cmd.mul_idx[1] ? mx[63:32] : mx[31:0];
        myj = i_cmd.mul_idx[0] ? my[63:32] : my[31:0];
    end

    assign wide_shl = {64'd0, r_rem} << r_s;

    assign {np_c, np_sum} = {1'b0, r_prod_p[63:0]} + {1'b0, r_p1};
    assign {nq_c, nq_sum} = {1'b0, r_acc[63:0]} + {1'b0, r_q1};
    assign ok_p = (r_p == 64'd0) ? (r_p1 <= rac_pkg::LIMIT) :
                  ((r_d[127:64] == 64'd0) && (r_prod_p[127:64] == 64'd0) && !np_c &&
                   (np_sum <= rac_pkg::LIMIT));
    assign ok_q = (r_q == 64'd0) ? (r_q1 <= rac_pkg::LIMIT) :
                  ((r_d[127:64] == 64'd0) && (r_acc[127:64] == 64'd0) && !nq_c &&
                   (nq_sum <= rac_pkg::LIMIT));
    assign np_val = (r_p == 64'd0) ? r_p1 : np_sum;
    assign nq_val = (r_q == 64'd0) ? r_q1 : nq_sum;

    assign o_stat.is_main = r_main;
    assign o_stat.fit_ok  = r_fit_ok;
    assign o_stat.stop    = !r_over && (r_shl <= r_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_shift <= rac_pkg::SHIFT_RESET;
            r_part_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_shift <= i_cfg_wdata;
            end
            r_part_vld <= i_cmd.mul_go;
            r_out_vld  <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sign  <= i_x_bits[63];
            r_s     <= r_cfg_shift;
            r_first <= 1'b1;
            r_main  <= 1'b0;
            r_p     <= 64'd0;
            r_q     <= 64'd1;
            r_p1    <= 64'd0;
            r_q1    <= 64'd1;
            r_a0    <= a0_init;
            r_b     <= b_init;
            r_d     <= {64'd0, a0_init};
            r_rem   <= '0;
            if (ex == 11'h7FF) begin
                r_status <= rac_pkg::ST_NAN;
            end else if (ex >= 11'd1086) begin
                r_status <= rac_pkg::ST_RANGE;
            end else begin
                r_status <= rac_pkg::ST_OK;
                if (ex >= 11'd960) begin
                    r_main <= 1'b1;
                    r_p    <= 64'd1;
                    r_q    <= 64'd0;
                end
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_ge ? (rem_sh - r_b) : rem_sh;
            r_d   <= {r_d[126:0], rem_ge};
        end
        if (i_cmd.mul_go) begin
            r_part    <= 64'(mxi * myj);
            r_part_sh <= 2'(i_cmd.mul_idx[1] + i_cmd.mul_idx[0]);
        end
        if (i_cmd.mul_clr) begin
            r_acc <= '0;
        end else if (r_part_vld) begin
            r_acc <= r_acc + ({64'd0, r_part} << {r_part_sh, 5'd0});
        end
        if (i_cmd.save_p) begin
            r_prod_p <= r_acc;
        end
        if (i_cmd.eval) begin
            r_fit_ok <= ok_p && ok_q;
            if (ok_p && ok_q) begin
                r_p1 <= r_p;
                r_q1 <= r_q;
                r_p  <= np_val;
                r_q  <= nq_val;
            end else if (r_first) begin
                r_status <= rac_pkg::ST_RANGE;
            end
        end
        if (i_cmd.shift) begin
            r_shl  <= wide_shl[127:0];
            r_over <= |wide_shl[191:128];
        end
        if (i_cmd.advance) begin
            r_d     <= r_b;
            r_b     <= r_rem;
            r_rem   <= '0;
            r_first <= 1'b0;
        end
        if (i_cmd.finish) begin
            r_out_st <= r_status;
            if (r_status != rac_pkg::ST_OK) begin
                r_num <= '0;
                r_den <= '0;
            end else begin
                r_num <= r_sign ? -$signed(r_p) : $signed(r_p);
                r_den <= r_q[62:0];
            end
        end
    end

    assign o_valid       = r_out_vld;
    assign o_numerator   = r_num;
    assign o_denominator = r_den;
    assign o_status      = r_out_st;

endmodule

### rtl/core/rational_approximation_core.sv
// ----------------------------------------------------------------------------
// Rational approximation core
// Continued-fraction convergent p/q of an IEEE binary64 value.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low, and its single
// result appears on the output ports for exactly one cycle with o_valid high;
// the receiver must take it then, since the core cannot hold it. Infinite,
// NaN, too large and tiny inputs go from the decide state straight to the
// done state. Other inputs run one continued-fraction term at a time: the
// bit-serial Euclid divider, two products on the shared 32x32 multiplier,
// the eval and fit states, a third product, and the shift and compare
// states. The tolerance register is written with i_cfg_we and takes effect
// at the next transaction.
module rational_approximation_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [5:0]         i_cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic [63:0]        i_x_bits,
    output logic               o_valid,
    output logic signed [63:0] o_numerator,
    output logic [62:0]        o_denominator,
    output logic [1:0]         o_status
);

    rac_pkg::t_dp_cmd  cmd;
    rac_pkg::t_dp_stat stat;

    rac_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rac_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_x_bits      (i_x_bits),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_numerator   (o_numerator),
        .o_denominator (o_denominator),
        .o_status      (o_status)
    );

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != rac_pkg::ST_OK)) |->
        ((o_numerator == 64'sd0) && (o_denominator == 63'd0)))
        else $error("failed transaction with nonzero result");

    a_ok_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == rac_pkg::ST_OK)) |-> (o_denominator != 63'd0))
        else $error("good transaction with zero denominator");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted transaction did not make the core busy");

endmodule
